### hdl/bvg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the calibration table of the battery voltage gauge.
// No dependencies.
package bvg_pkg;

    localparam int SAMPLES_DEF  = 30;
    localparam int TABLE_POINTS = 70;
    localparam int IDX_W        = $clog2(TABLE_POINTS);

    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 17;
    localparam int COUNT_W  = 6;
    localparam int PACK_W   = 15;
    localparam int CELL_W   = 14;
    localparam int PCT_W    = 7;
    localparam int CC_W     = 3;
    localparam int CUT_W    = 13;

    localparam int DIV_NUM_W = 27;
    localparam int DIV_DEN_W = 13;

    localparam logic CFG_CELL_COUNT = 1'b0;
    localparam logic CFG_CUTOFF_MV  = 1'b1;

    localparam logic [CC_W-1:0]  CELL_COUNT_RST = 3'd2;
    localparam logic [CUT_W-1:0] CUTOFF_RST     = 13'd3000;
    localparam logic [CC_W-1:0]  CELLS_MIN      = 3'd2;
    localparam logic [CC_W-1:0]  CELLS_MAX      = 3'd6;
    localparam logic [PCT_W-1:0] PERCENT_FULL   = 7'd100;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_SEARCH,
        ST_EDGE,
        ST_INT_MUL,
        ST_INT_GO,
        ST_INT_WAIT,
        ST_CELL_GO,
        ST_CELL_WAIT,
        ST_PCT_CHK,
        ST_PCT_MUL,
        ST_PCT_GO,
        ST_PCT_WAIT,
        ST_DONE
    } t_state;

    localparam logic [SAMPLE_W-1:0] CAL_CODE [0:TABLE_POINTS-1] = '{
        12'd4095, 12'd4080, 12'd4022, 12'd3969, 12'd3914, 12'd3861, 12'd3803, 12'd3755,
        12'd3705, 12'd3658, 12'd3610, 12'd3561, 12'd3516, 12'd3473, 12'd3433, 12'd3393,
        12'd3353, 12'd3316, 12'd3279, 12'd3244, 12'd3205, 12'd3170, 12'd3136, 12'd3100,
        12'd3044, 12'd2992, 12'd2941, 12'd2891, 12'd2840, 12'd2793, 12'd2741, 12'd2692,
        12'd2642, 12'd2593, 12'd2540, 12'd2491, 12'd2443, 12'd2393, 12'd2347, 12'd2296,
        12'd2251, 12'd2202, 12'd2155, 12'd2105, 12'd2056, 12'd2001, 12'd1953, 12'd1889,
        12'd1823, 12'd1758, 12'd1692, 12'd1626, 12'd1562, 12'd1489, 12'd1424, 12'd1359,
        12'd1294, 12'd1228, 12'd1161, 12'd1095, 12'd1030, 12'd959,  12'd894,  12'd829,
        12'd763,  12'd715,  12'd650,  12'd586,  12'd556,  12'd499
    };

    localparam logic [PACK_W-1:0] CAL_MV [0:TABLE_POINTS-1] = '{
        15'd24340, 15'd24140, 15'd23940, 15'd23740, 15'd23540, 15'd23340, 15'd23140,
        15'd22940, 15'd22740, 15'd22540, 15'd22340, 15'd22140, 15'd21940, 15'd21730,
        15'd21530, 15'd21330, 15'd21130, 15'd20930, 15'd20730, 15'd20530, 15'd20330,
        15'd20130, 15'd19930, 15'd19730, 15'd19430, 15'd19130, 15'd18830, 15'd18530,
        15'd18230, 15'd17930, 15'd17630, 15'd17330, 15'd17030, 15'd16730, 15'd16430,
        15'd16120, 15'd15820, 15'd15520, 15'd15220, 15'd14920, 15'd14620, 15'd14320,
        15'd14020, 15'd13720, 15'd13420, 15'd13120, 15'd12820, 15'd12420, 15'd12020,
        15'd11620, 15'd11220, 15'd10810, 15'd10410, 15'd10010, 15'd9610,  15'd9210,
        15'd8810,  15'd8410,  15'd8010,  15'd7610,  15'd7210,  15'd6810,  15'd6410,
        15'd6010,  15'd5610,  15'd5310,  15'd4910,  15'd4510,  15'd4210,  15'd4010
    };

endpackage

### hdl/bvg_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the sample input and the gauge result output.
// Depends on bvg_pkg for field widths.
interface bvg_in_if;
    logic                             valid;
    logic                             ready;
    logic [bvg_pkg::SAMPLE_W-1:0]     adc_sample;
    modport source (output valid, output adc_sample, input ready);
    modport sink (input valid, input adc_sample, output ready);
endinterface

interface bvg_out_if;
    logic                             valid;
    logic                             ready;
    logic [bvg_pkg::SAMPLE_W-1:0]     avg_code;
    logic [bvg_pkg::PACK_W-1:0]       pack_mv;
    logic [bvg_pkg::CELL_W-1:0]       cell_mv;
    logic [bvg_pkg::PCT_W-1:0]        charge_percent;
    modport source (output valid, output avg_code, output pack_mv, output cell_mv,
                    output charge_percent, input ready);
    modport sink (input valid, input avg_code, input pack_mv, input cell_mv,
                  input charge_percent, output ready);
endinterface

### hdl/bvg_div.sv
`timescale 1ns / 1ps
// Restoring divider that produces one quotient bit per cycle.
// No package dependencies.
module bvg_div #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q, n_q;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DEN_W:0]   trial;

    always_comb begin
        trial  = {r_rem, r_q[NUM_W-1]};
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_q    = i_num;
            n_rem  = '0;
            n_cnt  = CNT_W'(NUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = DEN_W'(trial - {1'b0, r_den});
                n_q   = {r_q[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DEN_W-1:0];
                n_q   = {r_q[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

### hdl/battery_voltage_gauge_unit.sv
`timescale 1ns / 1ps
// Top level of the battery voltage gauge: sample accumulation, table search and sequencer.
// Depends on bvg_pkg, bvg_if and bvg_div.
//
//  Channel   Direction  Transaction
//  i_in      in         one 12-bit ADC sample
//  o_out     out        avg_code, pack_mv, cell_mv, charge_percent
//  i_cfg_*   in         register write, index 0 cell_count, 1 cutoff_mv
//
// A sample that does not close a window is accepted whenever the unit is idle.
// The closing sample starts a conversion of up to four divisions on the shared divider
// (start, 27 quotient bits, done) plus a table search over up to 70 points and
// a few sequencing states before the result is valid.
// Reset is synchronous and active low; no clearing pass is needed.
// The closing sample is held off while a previous result waits on o_out.
module battery_voltage_gauge_unit #(
    parameter int SAMPLES = bvg_pkg::SAMPLES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bvg_in_if.sink                      i_in,
    bvg_out_if.source                   o_out,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [bvg_pkg::CUT_W-1:0]   i_cfg_data
);
    localparam int LAST = bvg_pkg::TABLE_POINTS - 1;
    localparam int NW   = bvg_pkg::DIV_NUM_W;
    localparam int DW   = bvg_pkg::DIV_DEN_W;

    bvg_pkg::t_state r_state, n_state;

    logic [bvg_pkg::CC_W-1:0]     r_cell_count;
    logic [bvg_pkg::CUT_W-1:0]    r_cutoff;
    logic [bvg_pkg::SUM_W-1:0]    r_sum, n_sum;
    logic [bvg_pkg::COUNT_W-1:0]  r_count, n_count;
    logic [bvg_pkg::SAMPLE_W-1:0] r_avg, n_avg;
    logic [bvg_pkg::IDX_W-1:0]    r_idx, n_idx;
    logic [bvg_pkg::SAMPLE_W-1:0] r_x1, n_x1;
    logic [bvg_pkg::PACK_W-1:0]   r_y1, n_y1;
    logic [bvg_pkg::PACK_W-1:0]   r_pack, n_pack;
    logic [bvg_pkg::CELL_W-1:0]   r_cell, n_cell;
    logic [bvg_pkg::PCT_W-1:0]    r_pct, n_pct;
    logic [14:0]                  r_mul_a, n_mul_a;
    logic [11:0]                  r_mul_b, n_mul_b;
    logic [NW-1:0]                r_prod;
    logic [DW-1:0]                r_dvs, n_dvs;
    logic                         r_out_valid, n_out_valid;

    logic                         in_acc;
    logic                         last_sample;
    logic [bvg_pkg::SAMPLE_W-1:0] code_i, code_p;
    logic [bvg_pkg::PACK_W-1:0]   mv_i, mv_p;
    logic [bvg_pkg::CC_W-1:0]     cells;
    logic signed [15:0]           pct_num, pct_den;
    logic                         div_start, div_done;
    logic [NW-1:0]                div_num, div_quot;
    logic [DW-1:0]                div_den;

    assign last_sample = (r_count == bvg_pkg::COUNT_W'(SAMPLES - 1));
    assign i_in.ready  = (r_state == bvg_pkg::ST_IDLE) && !(r_out_valid && last_sample);
    assign in_acc      = i_in.valid && i_in.ready;

    assign code_i = bvg_pkg::CAL_CODE[r_idx];
    assign mv_i   = bvg_pkg::CAL_MV[r_idx];
    assign code_p = bvg_pkg::CAL_CODE[r_idx - 1'b1];
    assign mv_p   = bvg_pkg::CAL_MV[r_idx - 1'b1];

    always_comb begin
        if (r_cell_count < bvg_pkg::CELLS_MIN) begin
            cells = bvg_pkg::CELLS_MIN;
        end else if (r_cell_count > bvg_pkg::CELLS_MAX) begin
            cells = bvg_pkg::CELLS_MAX;
        end else begin
            cells = r_cell_count;
        end
    end

    assign pct_num = $signed({2'b00, r_cell}) + 16'sd20 - $signed({3'b000, r_cutoff});
    assign pct_den = 16'sd4220 - $signed({3'b000, r_cutoff});

    always_comb begin
        div_start = 1'b0;
        div_num   = r_prod;
        div_den   = r_dvs;
        case (r_state)
            bvg_pkg::ST_AVG_GO: begin
                div_start = 1'b1;
                div_num   = NW'(r_sum);
                div_den   = DW'(SAMPLES);
            end
            bvg_pkg::ST_INT_GO: begin
                div_start = 1'b1;
            end
            bvg_pkg::ST_CELL_GO: begin
                div_start = 1'b1;
                div_num   = NW'(r_pack);
                div_den   = DW'(cells);
            end
            bvg_pkg::ST_PCT_GO: begin
                div_start = 1'b1;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    bvg_div #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_count     = r_count;
        n_avg       = r_avg;
        n_idx       = r_idx;
        n_x1        = r_x1;
        n_y1        = r_y1;
        n_pack      = r_pack;
        n_cell      = r_cell;
        n_pct       = r_pct;
        n_mul_a     = r_mul_a;
        n_mul_b     = r_mul_b;
        n_dvs       = r_dvs;
        n_out_valid = r_out_valid && !o_out.ready;
        case (r_state)
            bvg_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_sum   = r_sum + bvg_pkg::SUM_W'(i_in.adc_sample);
                    n_count = r_count + 1'b1;
                    if (last_sample) begin
                        n_state = bvg_pkg::ST_AVG_GO;
                    end
                end
            end
            bvg_pkg::ST_AVG_GO: begin
                n_state = bvg_pkg::ST_AVG_WAIT;
            end
            bvg_pkg::ST_AVG_WAIT: begin
                if (div_done) begin
                    n_avg   = div_quot[bvg_pkg::SAMPLE_W-1:0];
                    n_sum   = '0;
                    n_count = '0;
                    n_idx   = '0;
                    n_state = bvg_pkg::ST_SEARCH;
                end
            end
            bvg_pkg::ST_SEARCH: begin
                if (r_avg >= code_i) begin
                    if (r_idx == '0) begin
                        n_pack  = mv_i;
                        n_state = bvg_pkg::ST_CELL_GO;
                    end else begin
                        n_x1    = code_i;
                        n_y1    = mv_i;
                        n_state = bvg_pkg::ST_EDGE;
                    end
                end else if (r_idx == bvg_pkg::IDX_W'(LAST)) begin
                    n_pack  = mv_i;
                    n_state = bvg_pkg::ST_CELL_GO;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            bvg_pkg::ST_EDGE: begin
                if (code_p <= r_x1 || mv_p < r_y1) begin
                    n_pack  = r_y1;
                    n_state = bvg_pkg::ST_CELL_GO;
                end else begin
                    n_mul_a = mv_p - r_y1;
                    n_mul_b = r_avg - r_x1;
                    n_dvs   = DW'(code_p - r_x1);
                    n_state = bvg_pkg::ST_INT_MUL;
                end
            end
            bvg_pkg::ST_INT_MUL: begin
                n_state = bvg_pkg::ST_INT_GO;
            end
            bvg_pkg::ST_INT_GO: begin
                n_state = bvg_pkg::ST_INT_WAIT;
            end
            bvg_pkg::ST_INT_WAIT: begin
                if (div_done) begin
                    n_pack  = r_y1 + div_quot[bvg_pkg::PACK_W-1:0];
                    n_state = bvg_pkg::ST_CELL_GO;
                end
            end
            bvg_pkg::ST_CELL_GO: begin
                n_state = bvg_pkg::ST_CELL_WAIT;
            end
            bvg_pkg::ST_CELL_WAIT: begin
                if (div_done) begin
                    n_cell  = div_quot[bvg_pkg::CELL_W-1:0];
                    n_state = bvg_pkg::ST_PCT_CHK;
                end
            end
            bvg_pkg::ST_PCT_CHK: begin
                if (pct_num <= 16'sd0) begin
                    n_pct   = '0;
                    n_state = bvg_pkg::ST_DONE;
                end else if (pct_den <= 16'sd0) begin
                    n_pct   = bvg_pkg::PERCENT_FULL;
                    n_state = bvg_pkg::ST_DONE;
                end else begin
                    n_mul_a = pct_num[14:0];
                    n_mul_b = 12'(bvg_pkg::PERCENT_FULL);
                    n_dvs   = pct_den[DW-1:0];
                    n_state = bvg_pkg::ST_PCT_MUL;
                end
            end
            bvg_pkg::ST_PCT_MUL: begin
                n_state = bvg_pkg::ST_PCT_GO;
            end
            bvg_pkg::ST_PCT_GO: begin
                n_state = bvg_pkg::ST_PCT_WAIT;
            end
            bvg_pkg::ST_PCT_WAIT: begin
                if (div_done) begin
                    if (div_quot > NW'(bvg_pkg::PERCENT_FULL)) begin
                        n_pct = bvg_pkg::PERCENT_FULL;
                    end else begin
                        n_pct = div_quot[bvg_pkg::PCT_W-1:0];
                    end
                    n_state = bvg_pkg::ST_DONE;
                end
            end
            bvg_pkg::ST_DONE: begin
                n_out_valid = 1'b1;
                n_state     = bvg_pkg::ST_IDLE;
            end
            default: begin
                n_state = bvg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bvg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_cell_count <= bvg_pkg::CELL_COUNT_RST;
            r_cutoff     <= bvg_pkg::CUTOFF_RST;
        end else begin
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && i_cfg_idx == bvg_pkg::CFG_CELL_COUNT) begin
                r_cell_count <= i_cfg_data[bvg_pkg::CC_W-1:0];
            end
            if (i_cfg_we && i_cfg_idx == bvg_pkg::CFG_CUTOFF_MV) begin
                r_cutoff <= i_cfg_data;
            end
        end
        r_avg   <= n_avg;
        r_idx   <= n_idx;
        r_x1    <= n_x1;
        r_y1    <= n_y1;
        r_pack  <= n_pack;
        r_cell  <= n_cell;
        r_pct   <= n_pct;
        r_mul_a <= n_mul_a;
        r_mul_b <= n_mul_b;
        r_dvs   <= n_dvs;
        r_prod  <= NW'(r_mul_a) * NW'(r_mul_b);
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.avg_code       = r_avg;
    assign o_out.pack_mv        = r_pack;
    assign o_out.cell_mv        = r_cell;
    assign o_out.charge_percent = r_pct;

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != bvg_pkg::ST_IDLE |-> !i_in.ready)
        else $error("input ready while a conversion is running");

    a_count_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bvg_pkg::COUNT_W'(SAMPLES))
        else $error("sample count left the window");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.charge_percent <= bvg_pkg::PERCENT_FULL)
        else $error("charge percent above full");

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == bvg_pkg::ST_AVG_WAIT || r_state == bvg_pkg::ST_INT_WAIT
                      || r_state == bvg_pkg::ST_CELL_WAIT || r_state == bvg_pkg::ST_PCT_WAIT))
        else $error("divider finished outside a wait state");
endmodule
